// File: design/wrs_pkg.sv
package wrs_pkg;

    // Request kinds
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [31:0] weight;
        logic [7:0]  entry_id;
        logic [31:0] random_fraction;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [7:0] selected_id;
        logic [4:0] entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_MUL,
        S_DRAW_RD,
        S_DRAW_CMP,
        S_EMIT
    } t_state;

endpackage

// File: design/wrs_stream_if.sv
interface wrs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/wrs_mul.sv
module wrs_mul #(
    parameter int A_W = 36,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_product
);
    localparam int P_W  = A_W + B_W;
    localparam int CW   = $clog2(B_W + 1);

    logic [P_W-1:0] r_acc, n_acc;
    logic [P_W-1:0] r_a, n_a;
    logic [B_W-1:0] r_b, n_b;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;

    // Shift and add one multiplier bit per cycle
    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = P_W'(i_a);
            n_b    = i_b;
            n_cnt  = CW'(B_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("multiply started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held longer than one cycle");
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1)) |=> (r_done && !r_busy))
        else $error("multiply did not finish after last bit");

endmodule

// File: design/weighted_random_selector.sv
// Weighted random selector: a table of up to ENTRIES (weight, id) entries kept sorted by
// weight, largest first, with a running sum stored next to each entry. An add request walks
// the table once through its single-port memories, placing the new entry ahead of the first
// one whose weight is not greater and rebuilding the running sums with one adder. A draw
// request first forms u*total in a shift-add multiplier, one bit of u per cycle, then scans
// the running sums until u*total <= sum*2^RAND_BITS or the last entry is reached. An add to
// a full table or a draw on an empty one goes straight to the output stage. One request
// is worked on at a time; the next is taken while a finished result still waits at the output.
module weighted_random_selector #(
    parameter int ENTRIES     = 16,
    parameter int WEIGHT_BITS = 32,
    parameter int RAND_BITS   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wrs_stream_if.sink    i_req,
    wrs_stream_if.source  o_rsp
);
    import wrs_pkg::*;

    localparam int W_IN   = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SUM_W  = W_IN + IDX_W;
    localparam int PROD_W = SUM_W + RAND_BITS;

    typedef struct packed {
        logic [W_IN-1:0] w;
        logic [7:0]      id;
    } t_tbl_entry;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [7:0]       id;
    } t_sum_entry;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_total, n_total;
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_inserted, n_inserted;
    t_tbl_entry        r_carry, n_carry;
    t_tbl_entry        r_new, n_new;
    logic [PROD_W-1:0] r_prod, n_prod;
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_tbl_entry        r_tbl [ENTRIES];
    t_sum_entry        r_sum_mem [ENTRIES];
    t_tbl_entry        r_tbl_rd;
    t_sum_entry        r_sum_rd;

    logic              tbl_we;
    t_tbl_entry        tbl_wdata;
    logic              sum_we;
    t_sum_entry        sum_wdata;

    logic              req_acc;
    logic              mul_start;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;

    logic              at_end;
    logic              take_new;
    t_tbl_entry        add_ent;
    logic [SUM_W-1:0]  sum_next;
    logic              hit;
    logic              last;

    assign i_req.ready   = (r_state == S_IDLE);
    assign req_acc       = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Form u * total for a draw
    wrs_mul #(
        .A_W (SUM_W),
        .B_W (RAND_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_total),
        .i_b       (i_req.payload.random_fraction[RAND_BITS-1:0]),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // Insert step: pick what goes into the current slot and its running sum
    assign at_end   = (CNT_W'(r_idx) == r_count);
    assign take_new = !r_inserted && (at_end || (r_new.w >= r_tbl_rd.w));
    assign add_ent  = take_new ? r_new : (r_inserted ? r_carry : r_tbl_rd);
    assign sum_next = r_acc + SUM_W'(add_ent.w);

    // Draw step: exact compare against the scaled running sum
    assign hit  = (r_prod <= {r_sum_rd.sum, {RAND_BITS{1'b0}}});
    assign last = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_acc       = r_acc;
        n_idx       = r_idx;
        n_inserted  = r_inserted;
        n_carry     = r_carry;
        n_new       = r_new;
        n_prod      = r_prod;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        tbl_we      = 1'b0;
        tbl_wdata   = add_ent;
        sum_we      = 1'b0;
        sum_wdata   = '{sum: sum_next, id: add_ent.id};
        mul_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_res.status      = ST_OK;
                    n_res.position    = '0;
                    n_res.selected_id = '0;
                    n_res.entry_count = 5'(r_count);
                    if (i_req.payload.mode == MODE_ADD) begin
                        if (r_count >= CNT_W'(ENTRIES)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_EMIT;
                        end else begin
                            n_new.w    = i_req.payload.weight[W_IN-1:0];
                            n_new.id   = i_req.payload.entry_id;
                            n_idx      = '0;
                            n_acc      = '0;
                            n_inserted = 1'b0;
                            n_state    = S_ADD_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_EMIT;
                        end else begin
                            mul_start = 1'b1;
                            n_state   = S_MUL;
                        end
                    end
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                // Shift the table down one slot behind the inserted entry
                tbl_we = take_new || r_inserted;
                sum_we = 1'b1;
                n_acc  = sum_next;
                if (take_new || r_inserted) begin
                    n_carry = r_tbl_rd;
                end
                if (take_new) begin
                    n_inserted     = 1'b1;
                    n_res.position = 4'(r_idx);
                end
                if (at_end) begin
                    n_count           = r_count + CNT_W'(1);
                    n_total           = sum_next;
                    n_res.entry_count = 5'(r_count + CNT_W'(1));
                    n_state           = S_EMIT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_ADD_RD;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_prod  = mul_product;
                    n_idx   = '0;
                    n_state = S_DRAW_RD;
                end
            end
            S_DRAW_RD: begin
                n_state = S_DRAW_CMP;
            end
            S_DRAW_CMP: begin
                // Stop at the first running sum that covers the draw, or at the last entry
                if (hit || last) begin
                    n_res.position    = 4'(r_idx);
                    n_res.selected_id = r_sum_rd.id;
                    n_state           = S_EMIT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_DRAW_RD;
                end
            end
            S_EMIT: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_inserted  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_inserted  <= n_inserted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_acc   <= n_acc;
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_new   <= n_new;
        r_prod  <= n_prod;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Entry table: one write, one registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[r_idx] <= tbl_wdata;
        end
        r_tbl_rd <= r_tbl[r_idx];
    end

    // Running sum table with the id of each slot
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[r_idx] <= sum_wdata;
        end
        r_sum_rd <= r_sum_mem[r_idx];
    end

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR && at_end) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count did not advance after insert");
    a_add_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR) |-> (r_count < CNT_W'(ENTRIES)))
        else $error("insert into a full table");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW_CMP) |-> (CNT_W'(r_idx) < r_count))
        else $error("draw scan ran past the table");
    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiply finished outside a draw");
    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || o_rsp.ready))
        |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

endmodule
